// ----- hw/rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGES_DEF = 4096;
  localparam int RANKS_DEF = 16;

  localparam int RK_W  = 5;   // rank field width
  localparam int SZ_W  = 17;  // width for block sizes and page compares
  localparam int TP_W  = 13;  // page limit register width
  localparam int VAL_W = 13;
  localparam int PG_W  = 16;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_NOSPC = 2'd2;

  typedef struct packed {
    logic [2:0]      op;
    logic [PG_W-1:0] page;
    logic [RK_W-1:0] req_rank;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
  } bpa_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bpa_ctl_t;

  // pages in a block of the given rank
  function automatic logic [SZ_W-1:0] blk_sz(input logic [RK_W-1:0] r);
    logic [RK_W-1:0] sh;
    sh = r - RK_W'(1);
    return SZ_W'(1) << sh;
  endfunction

endpackage

// ----- hw/rtl/bpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: free list heads and counts in registers,
// per-page words (flags, rank, doubly linked list pointers) in the page RAM.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; #(
  parameter int PAGES = PAGES_DEF,
  parameter int RANKS = RANKS_DEF,
  parameter int AW    = (PAGES > 1) ? $clog2(PAGES) : 1,
  parameter int EW    = 8 + 2 * AW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bpa_in_t         cmd_i,
  input  logic [TP_W-1:0] page_limit_i,
  input  logic            res_take_i,
  output bpa_ctl_t        ctl_o,
  output bpa_out_t        res_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [EW-1:0]   mem_wdata_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [EW-1:0]   mem_rdata_i
);

  localparam int MW   = $clog2(PAGES + 1);
  localparam int RI_W = (RANKS > 1) ? $clog2(RANKS) : 1;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_PUSH_A = 4'd3;
  localparam logic [3:0] S_PUSH_B = 4'd4;
  localparam logic [3:0] S_A1     = 4'd5;
  localparam logic [3:0] S_A2     = 4'd6;
  localparam logic [3:0] S_F1     = 4'd7;
  localparam logic [3:0] S_F2     = 4'd8;
  localparam logic [3:0] S_F3     = 4'd9;
  localparam logic [3:0] S_F4     = 4'd10;
  localparam logic [3:0] S_F5     = 4'd11;
  localparam logic [3:0] S_Q1     = 4'd12;
  localparam logic [3:0] S_Q2     = 4'd13;
  localparam logic [3:0] S_Q3     = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0]       st_q, st_d, ret_q, ret_d;
  logic             init_q, init_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [MW-1:0]    managed_q, managed_d;
  logic [MW-1:0]    off_q, off_d;
  logic [AW-1:0]    head_q [RANKS];
  logic [AW-1:0]    head_d [RANKS];
  logic [MW-1:0]    cnt_q [RANKS];
  logic [MW-1:0]    cnt_d [RANKS];
  logic [AW-1:0]    cur_q, cur_d, bud_q, bud_d, pn_q, pn_d, oh_q, oh_d;
  logic [RK_W-1:0]  rk_q, rk_d, r_q, r_d, s_q, s_d, pr_q, pr_d;
  logic [AW-1:0]    ub_nx_q, ub_nx_d, ub_pv_q, ub_pv_d;
  logic             ub_has_q, ub_has_d;
  logic [1:0]       rst_q, rst_d;
  logic [VAL_W-1:0] rval_q, rval_d;

  // fields of the page word read back
  logic            rd_alloc, rd_fhead, rd_has;
  logic [RK_W-1:0] rd_rank;
  logic [AW-1:0]   rd_nx, rd_pv;

  assign rd_alloc = mem_rdata_i[EW-1];
  assign rd_fhead = mem_rdata_i[EW-2];
  assign rd_has   = mem_rdata_i[EW-3];
  assign rd_rank  = mem_rdata_i[EW-4 -: RK_W];
  assign rd_nx    = mem_rdata_i[2*AW-1:AW];
  assign rd_pv    = mem_rdata_i[AW-1:0];

  logic [RI_W-1:0] pidx, ridx, sidx, kidx;
  assign pidx = RI_W'(pr_q - RK_W'(1));
  assign ridx = RI_W'(r_q - RK_W'(1));
  assign sidx = RI_W'(s_q - RK_W'(1));
  assign kidx = RI_W'(cmd_i.req_rank - RK_W'(1));

  logic            rk_ok, pg_oor, fnd;
  logic [RK_W-1:0] fnd_s, best, rk_cl, s_dn;
  logic [SZ_W-1:0] rem, tp_w, bud_w, qcand_w, split_w;

  assign rk_ok  = (cmd_i.req_rank >= RK_W'(1)) && (cmd_i.req_rank <= RK_W'(RANKS));
  assign pg_oor = SZ_W'(cmd_i.page) >= SZ_W'(managed_q);
  assign rem    = SZ_W'(managed_q) - SZ_W'(off_q);
  assign tp_w   = SZ_W'(page_limit_i);
  assign bud_w  = SZ_W'(cur_q) ^ blk_sz(r_q);
  assign qcand_w = SZ_W'(cur_q) & ~(blk_sz(r_q) - SZ_W'(1));
  assign s_dn    = s_q - RK_W'(1);
  assign split_w = SZ_W'(cur_q) + blk_sz(s_dn);

  // first nonempty list at or above the requested rank
  always_comb begin
    fnd   = 1'b0;
    fnd_s = '0;
    for (int i = 0; i < RANKS; i++) begin
      if (!fnd && cnt_q[i] != '0 && RK_W'(i + 1) >= cmd_i.req_rank) begin
        fnd   = 1'b1;
        fnd_s = RK_W'(i + 1);
      end
    end
  end

  // largest aligned block that fits at the init offset
  always_comb begin
    logic [SZ_W-1:0] sz;
    best = RK_W'(1);
    for (int i = 0; i < RANKS; i++) begin
      sz = blk_sz(RK_W'(i + 1));
      if (sz <= rem && (SZ_W'(off_q) & (sz - SZ_W'(1))) == '0) begin
        best = RK_W'(i + 1);
      end
    end
  end

  always_comb begin
    if (rd_rank < RK_W'(1)) begin
      rk_cl = RK_W'(1);
    end else if (rd_rank > RK_W'(RANKS)) begin
      rk_cl = RK_W'(RANKS);
    end else begin
      rk_cl = rd_rank;
    end
  end

  always_comb begin
    st_d      = st_q;
    ret_d     = ret_q;
    init_d    = init_q;
    clr_d     = clr_q;
    managed_d = managed_q;
    off_d     = off_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    bud_d     = bud_q;
    pn_d      = pn_q;
    oh_d      = oh_q;
    rk_d      = rk_q;
    r_d       = r_q;
    s_d       = s_q;
    pr_d      = pr_q;
    ub_nx_d   = ub_nx_q;
    ub_pv_d   = ub_pv_q;
    ub_has_d  = ub_has_q;
    rst_d     = rst_q;
    rval_d    = rval_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = '0;
    mem_raddr_o = cur_q;

    case (st_q)
      S_CLR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(PAGES - 1)) begin
          clr_d  = '0;
          init_d = 1'b0;
          off_d  = '0;
          st_d   = init_q ? S_INIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          rk_d   = cmd_i.req_rank;
          cur_d  = cmd_i.page[AW-1:0];
          rst_d  = ST_INVAL;
          rval_d = '0;
          st_d   = S_DONE;
          case (cmd_i.op)
            OP_INIT: begin
              if (page_limit_i != '0) begin
                managed_d = (tp_w > SZ_W'(PAGES)) ? MW'(PAGES) : MW'(page_limit_i);
                for (int i = 0; i < RANKS; i++) begin
                  head_d[i] = '0;
                  cnt_d[i]  = '0;
                end
                clr_d  = '0;
                init_d = 1'b1;
                st_d   = S_CLR;
              end
            end
            OP_ALLOC: begin
              if (rk_ok && !fnd) begin
                rst_d = ST_NOSPC;
              end else if (rk_ok) begin
                mem_raddr_o = head_q[RI_W'(fnd_s - RK_W'(1))];
                cur_d       = head_q[RI_W'(fnd_s - RK_W'(1))];
                s_d         = fnd_s;
                st_d        = S_A1;
              end
            end
            OP_FREE: begin
              if (!pg_oor) begin
                mem_raddr_o = cmd_i.page[AW-1:0];
                st_d        = S_F1;
              end
            end
            OP_QUERY: begin
              if (!pg_oor) begin
                mem_raddr_o = cmd_i.page[AW-1:0];
                st_d        = S_Q1;
              end
            end
            OP_COUNT: begin
              if (rk_ok) begin
                rst_d  = ST_OK;
                rval_d = VAL_W'(cnt_q[kidx]);
              end
            end
            default: begin
              rst_d = ST_INVAL;
            end
          endcase
        end
      end
      S_INIT: begin
        if (rem == '0) begin
          rst_d  = ST_OK;
          rval_d = '0;
          st_d   = S_DONE;
        end else begin
          pr_d  = best;
          pn_d  = off_q[AW-1:0];
          off_d = off_q + MW'(blk_sz(best));
          ret_d = S_INIT;
          st_d  = S_PUSH_A;
        end
      end
      S_PUSH_A: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pn_q;
        mem_wdata_o = {1'b0, 1'b1, cnt_q[pidx] != '0, pr_q, head_q[pidx], AW'(0)};
        mem_raddr_o = head_q[pidx];
        oh_d        = head_q[pidx];
        head_d[pidx] = pn_q;
        cnt_d[pidx]  = cnt_q[pidx] + MW'(1);
        st_d         = (cnt_q[pidx] != '0) ? S_PUSH_B : ret_q;
      end
      S_PUSH_B: begin
        // old head gets its back link
        mem_we_o    = 1'b1;
        mem_waddr_o = oh_q;
        mem_wdata_o = {mem_rdata_i[EW-1:AW], pn_q};
        st_d        = ret_q;
      end
      S_A1: begin
        head_d[sidx] = rd_nx;
        cnt_d[sidx]  = cnt_q[sidx] - MW'(1);
        st_d         = S_A2;
      end
      S_A2: begin
        if (s_q > rk_q) begin
          s_d   = s_dn;
          pr_d  = s_dn;
          pn_d  = split_w[AW-1:0];
          ret_d = S_A2;
          st_d  = S_PUSH_A;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = {1'b1, 1'b0, 1'b0, rk_q, AW'(0), AW'(0)};
          rst_d       = ST_OK;
          rval_d      = VAL_W'(cur_q);
          st_d        = S_DONE;
        end
      end
      S_F1: begin
        if (!rd_alloc) begin
          st_d = S_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = {1'b0, mem_rdata_i[EW-2:0]};
          r_d         = rk_cl;
          st_d        = S_F2;
        end
      end
      S_F2: begin
        rst_d  = ST_OK;
        rval_d = '0;
        if (r_q < RK_W'(RANKS) && bud_w < SZ_W'(managed_q)) begin
          mem_raddr_o = bud_w[AW-1:0];
          bud_d       = bud_w[AW-1:0];
          st_d        = S_F3;
        end else begin
          pr_d  = r_q;
          pn_d  = cur_q;
          ret_d = S_DONE;
          st_d  = S_PUSH_A;
        end
      end
      S_F3: begin
        if (rd_alloc || !rd_fhead || rd_rank != r_q) begin
          pr_d  = r_q;
          pn_d  = cur_q;
          ret_d = S_DONE;
          st_d  = S_PUSH_A;
        end else begin
          // unlink the buddy, then merge one rank up
          mem_we_o    = 1'b1;
          mem_waddr_o = bud_q;
          mem_wdata_o = {1'b0, 1'b0, mem_rdata_i[EW-3:0]};
          ub_nx_d     = rd_nx;
          ub_pv_d     = rd_pv;
          ub_has_d    = rd_has;
          cnt_d[ridx] = cnt_q[ridx] - MW'(1);
          cur_d       = (bud_q < cur_q) ? bud_q : cur_q;
          r_d         = r_q + RK_W'(1);
          if (bud_q == head_q[ridx]) begin
            head_d[ridx] = rd_nx;
            st_d         = S_F2;
          end else begin
            mem_raddr_o = rd_pv;
            st_d        = S_F4;
          end
        end
      end
      S_F4: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ub_pv_q;
        mem_wdata_o = {mem_rdata_i[EW-1:EW-2], ub_has_q, mem_rdata_i[EW-4 -: RK_W],
                       ub_nx_q, mem_rdata_i[AW-1:0]};
        mem_raddr_o = ub_nx_q;
        st_d        = ub_has_q ? S_F5 : S_F2;
      end
      S_F5: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ub_nx_q;
        mem_wdata_o = {mem_rdata_i[EW-1:AW], ub_pv_q};
        st_d        = S_F2;
      end
      S_Q1: begin
        if (rd_alloc) begin
          rst_d  = ST_OK;
          rval_d = VAL_W'(rd_rank);
          st_d   = S_DONE;
        end else begin
          r_d  = RK_W'(RANKS);
          st_d = S_Q2;
        end
      end
      S_Q2: begin
        // free blocks are aligned, so the candidate head is the page rounded down
        mem_raddr_o = qcand_w[AW-1:0];
        st_d        = S_Q3;
      end
      S_Q3: begin
        if (rd_fhead && !rd_alloc && rd_rank == r_q) begin
          rst_d  = ST_OK;
          rval_d = VAL_W'(r_q);
          st_d   = S_DONE;
        end else if (r_q == RK_W'(1)) begin
          rst_d = ST_INVAL;
          st_d  = S_DONE;
        end else begin
          r_d  = r_q - RK_W'(1);
          st_d = S_Q2;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLR;
      init_q    <= 1'b0;
      clr_q     <= '0;
      managed_q <= '0;
      for (int i = 0; i < RANKS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      st_q      <= st_d;
      init_q    <= init_d;
      clr_q     <= clr_d;
      managed_q <= managed_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q    <= ret_d;
    off_q    <= off_d;
    cur_q    <= cur_d;
    bud_q    <= bud_d;
    pn_q     <= pn_d;
    oh_q     <= oh_d;
    rk_q     <= rk_d;
    r_q      <= r_d;
    s_q      <= s_d;
    pr_q     <= pr_d;
    ub_nx_q  <= ub_nx_d;
    ub_pv_q  <= ub_pv_d;
    ub_has_q <= ub_has_d;
    rst_q    <= rst_d;
    rval_q   <= rval_d;
  end

  assign ctl_o.busy   = st_q != S_IDLE;
  assign ctl_o.done   = st_q == S_DONE;
  assign res_o.status = rst_q;
  assign res_o.value  = rval_q;

endmodule

// ----- hw/rtl/buddy_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator over page indices: init, alloc, free, rank query and
// free block count, one result item per input item.
// ----------------------------------------------------------------------------
// Usage:
//  - input items (op, page, req_rank) enter on in_valid_i when in_stall_o is
//    low; one item is worked on at a time, in_stall_o stays high until its
//    result has moved into the output register
//  - result items (status, value) leave on out_valid_o, held while
//    out_stall_i is high; the next item is taken while a result waits
//  - cfg_we_i writes the page limit, read by the next init only
//  - an item runs as a sequence of steps on the page RAM, which has one
//    read port and one write port: count takes no RAM step, query probes
//    the candidate head of each rank from the top down, alloc pushes the
//    spare half of each split rank and free merges one rank at a time
//  - init clears the page RAM, one entry per cycle, then pushes each
//    greedy block onto its free list
//  - after reset the same clearing pass runs before the first item is
//    taken; no pages are managed until the first init
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int PAGES = PAGES_DEF,
  parameter int RANKS = RANKS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bpa_in_t         in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bpa_out_t        out_item_o,
  input  logic            cfg_we_i,
  input  logic [TP_W-1:0] cfg_wdata_i
);

  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int EW = 8 + 2 * AW;

  logic [TP_W-1:0] total_q;
  logic            out_valid_q, out_valid_d;
  bpa_out_t        out_item_q;
  bpa_ctl_t        ctl;
  bpa_out_t        res;
  logic            take;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [EW-1:0]   mem_wdata, mem_rdata;

  assign take = !out_valid_q || !out_stall_i;

  bpa_ctrl #(
    .PAGES (PAGES),
    .RANKS (RANKS),
    .AW    (AW),
    .EW    (EW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_valid_i && !ctl.busy),
    .cmd_i        (in_item_i),
    .page_limit_i (total_q),
    .res_take_i   (take),
    .ctl_o        (ctl),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  bpa_ram #(
    .W  (EW),
    .D  (PAGES),
    .AW (AW)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.done && take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TP_W'(4096);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.done && take) begin
      out_item_q <= res;
    end
  end

  assign in_stall_o  = ctl.busy;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("allocator took an item without going busy");

  a_value_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != ST_OK) |-> out_item_o.value == '0)
    else $error("nonzero value on a failed item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == ST_OK || out_item_o.status == ST_INVAL ||
                     out_item_o.status == ST_NOSPC))
    else $error("unknown status code");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.done && take) |=> !ctl.done)
    else $error("result delivered twice");
`endif

endmodule
